// ===== rtl/tle_pkg.sv =====
`default_nettype none
package tle_pkg;

  // Line store never holds more than this many entries.
  localparam int unsigned MAX_STORE  = 16;
  localparam int unsigned LINE_DEPTH_DEF = 16;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CFG_LINE_W = 5;

  // Character codes
  localparam logic [7:0] CH_BEL = 8'd7;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_NAK = 8'd21;
  localparam logic [7:0] CH_ESC = 8'd27;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_AST = 8'd42;
  localparam logic [7:0] CH_DEL = 8'd127;
  localparam logic [7:0] CH_PRINT_END = 8'd128;
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_IAC  = 8'd255;

  // Result kinds (tuser)
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ECHO,
    CMD_RUBOUT,
    CMD_LINE
  } cmd_op_e;

  // One work request from front to back.
  typedef struct packed {
    cmd_op_e          op;
    logic [7:0]       data;
    logic [LEN_W-1:0] cnt;
  } cmd_t;

  // Line store write port.
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage
`default_nettype wire

// ===== rtl/tle_front.sv =====
`default_nettype none
module tle_front import tle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  rx_valid_i,
  output logic                       rx_ready_o,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [CFG_LINE_W-1:0] max_line_i,
  input  wire logic                  hidden_i,
  input  wire logic                  q_ready_i,
  output logic                       q_push_o,
  output cmd_t                       q_cmd_o,
  output store_wr_t                  wr_o,
  input  wire logic                  line_done_i
);

  localparam int unsigned STORE_DEPTH = (LINE_DEPTH < MAX_STORE) ? LINE_DEPTH : MAX_STORE;
  localparam logic [CFG_LINE_W-1:0] STORE_LIM = CFG_LINE_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMD,
    PH_OPT
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [7:0]       prev_q, prev_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;

  logic                  accept;
  logic [CFG_LINE_W-1:0] lim;
  logic                  room;

  assign rx_ready_o = q_ready_i && !pend_q;
  assign accept     = rx_valid_i && rx_ready_o;
  assign lim        = (max_line_i > STORE_LIM) ? STORE_LIM : max_line_i;
  assign room       = ((CFG_LINE_W'(cnt_q) + CFG_LINE_W'(1)) < lim);

  always_comb begin
    phase_d  = phase_q;
    prev_d   = prev_q;
    cnt_d    = cnt_q;
    pend_d   = pend_q && !line_done_i;
    q_push_o = 1'b0;
    q_cmd_o  = '{op: CMD_ECHO, data: rx_byte_i, cnt: cnt_q};
    wr_o     = '{en: 1'b0, addr: cnt_q, data: rx_byte_i};
    if (accept) begin
      case (phase_q)
        PH_CMD: begin
          phase_d = (rx_byte_i >= TN_WILL && rx_byte_i != TN_IAC) ? PH_OPT : PH_IDLE;
        end
        PH_OPT: begin
          phase_d = PH_IDLE;
        end
        default: begin
          if ((rx_byte_i == CH_LF && prev_q == CH_CR) ||
              (rx_byte_i == CH_CR && prev_q == CH_LF)) begin
            prev_d = 8'd0;
          end else begin
            prev_d = rx_byte_i;
            if (rx_byte_i == TN_IAC) begin
              phase_d = PH_CMD;
            end else if (rx_byte_i inside {CH_CR, CH_LF}) begin
              q_push_o   = 1'b1;
              q_cmd_o.op = CMD_LINE;
              cnt_d      = '0;
              pend_d     = 1'b1;
            end else if (rx_byte_i inside {CH_BS, CH_DEL}) begin
              q_push_o = 1'b1;
              if (cnt_q == '0) begin
                q_cmd_o.op   = CMD_ECHO;
                q_cmd_o.data = CH_BEL;
              end else begin
                q_cmd_o.op  = CMD_RUBOUT;
                q_cmd_o.cnt = LEN_W'(1);
                cnt_d       = cnt_q - LEN_W'(1);
              end
            end else if (rx_byte_i inside {CH_ESC, CH_NAK}) begin
              if (cnt_q != '0) begin
                q_push_o   = 1'b1;
                q_cmd_o.op = CMD_RUBOUT;
                cnt_d      = '0;
              end
            end else if (rx_byte_i >= CH_SP && rx_byte_i < CH_PRINT_END) begin
              if (room) begin
                q_push_o     = 1'b1;
                q_cmd_o.data = hidden_i ? CH_AST : rx_byte_i;
                wr_o.en      = 1'b1;
                cnt_d        = cnt_q + LEN_W'(1);
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= 8'd0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tle_cmd_fifo.sv =====
`default_nettype none
module tle_cmd_fifo import tle_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tle_back.sv =====
`default_nettype none
module tle_back import tle_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire cmd_t             q_cmd_i,
  output logic                  q_pop_o,
  output logic [LEN_W-1:0]      rd_addr_o,
  input  wire logic [7:0]       rd_data_i,
  output logic                  line_done_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [1:0]            out_kind_o,
  output logic [7:0]            out_byte_o,
  output logic [LEN_W-1:0]      out_len_o,
  output logic                  out_last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_RUB,
    S_CRLF,
    S_TRIM,
    S_LINE,
    S_END
  } state_e;

  state_e           state_q;
  logic [7:0]       byte_q;
  logic [LEN_W-1:0] cnt_q;   // rubout groups left, or line length
  logic [LEN_W-1:0] idx_q;
  logic [1:0]       ph_q;
  logic             can_emit;

  assign can_emit    = !out_valid_o || out_ready_i;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign rd_addr_o   = (state_q == S_TRIM) ? (cnt_q - LEN_W'(1)) : idx_q;
  assign line_done_o = (state_q == S_END) && can_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      byte_q      <= 8'd0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ph_q        <= 2'd0;
      out_valid_o <= 1'b0;
      out_kind_o  <= KIND_ECHO;
      out_byte_o  <= 8'd0;
      out_len_o   <= '0;
      out_last_o  <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            byte_q <= q_cmd_i.data;
            cnt_q  <= q_cmd_i.cnt;
            ph_q   <= 2'd0;
            case (q_cmd_i.op)
              CMD_RUBOUT: state_q <= S_RUB;
              CMD_LINE:   state_q <= S_CRLF;
              default:    state_q <= S_ECHO;
            endcase
          end
        end
        S_ECHO: begin
          if (can_emit) begin
            out_valid_o <= 1'b1;
            out_kind_o  <= KIND_ECHO;
            out_byte_o  <= byte_q;
            out_len_o   <= '0;
            out_last_o  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_RUB: begin
          if (can_emit) begin
            out_valid_o <= 1'b1;
            out_kind_o  <= KIND_ECHO;
            out_byte_o  <= (ph_q == 2'd1) ? CH_SP : CH_BS;
            out_len_o   <= '0;
            out_last_o  <= (ph_q == 2'd2) && (cnt_q == LEN_W'(1));
            if (ph_q == 2'd2) begin
              ph_q  <= 2'd0;
              cnt_q <= cnt_q - LEN_W'(1);
              if (cnt_q == LEN_W'(1)) state_q <= S_IDLE;
            end else begin
              ph_q <= ph_q + 2'd1;
            end
          end
        end
        S_CRLF: begin
          if (can_emit) begin
            out_valid_o <= 1'b1;
            out_kind_o  <= KIND_ECHO;
            out_byte_o  <= (ph_q == 2'd0) ? CH_CR : CH_LF;
            out_len_o   <= '0;
            out_last_o  <= 1'b0;
            ph_q        <= 2'd1;
            if (ph_q != 2'd0) state_q <= S_TRIM;
          end
        end
        S_TRIM: begin
          // walk back over trailing spaces, one entry a cycle
          if (cnt_q != '0 && rd_data_i == CH_SP) begin
            cnt_q <= cnt_q - LEN_W'(1);
          end else begin
            idx_q   <= '0;
            state_q <= S_LINE;
          end
        end
        S_LINE: begin
          if (idx_q == cnt_q) begin
            state_q <= S_END;
          end else if (can_emit) begin
            out_valid_o <= 1'b1;
            out_kind_o  <= KIND_LINE;
            out_byte_o  <= rd_data_i;
            out_len_o   <= '0;
            out_last_o  <= 1'b0;
            idx_q       <= idx_q + LEN_W'(1);
          end
        end
        S_END: begin
          if (can_emit) begin
            out_valid_o <= 1'b1;
            out_kind_o  <= KIND_END;
            out_byte_o  <= 8'd0;
            out_len_o   <= cnt_q;
            out_last_o  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/terminal_line_editor.sv =====
`default_nettype none
// Terminal line editor with telnet filter.
// Slave stream: one received terminal byte per beat (tdata[7:0]).
// Master stream: result beats. tuser = kind (0 echo, 1 line byte, 2 line
//   end), tdata[7:0] = byte, tdata[11:8] = trimmed line length on the end
//   marker, tlast marks the final beat caused by one input byte.
// APB port: reg 0 at 0x0 max_line (5 bits), reg 1 at 0x4 hidden_echo.
//   pready is tied high; write config only while the block is idle.
// Flow: the front filters and classifies each byte in the cycle it is
//   accepted and pushes at most one command into a 2-deep queue; the back
//   expands commands into beats through a single output register.
// Input to output: queue, back command registers, output register.
// Throughput: one input beat per cycle while the queue has room; the back
//   drives one beat per cycle while the master accepts beats. Beats per
//   command: echo 1, rubout 3 per char, line 2 + len + 1 with len the
//   trimmed length. The back fetches each command from the queue first,
//   and a line end walks back over trailing spaces, then walks the store
//   to send the line. New input is held off from a line end until its end
//   marker is sent, since the store is reused.
// Reset: line empty, filter idle, max_line 16, hidden_echo 0, no beats.
// Stall: master tready low holds the output beat; the queue then fills and
//   the slave tready drops.
module terminal_line_editor import tle_pkg::*; #(
  parameter int unsigned LINE_DEPTH = LINE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_byte, [11:8] line_length
  output logic [1:0]       m_axis_tuser_o,   // [1:0] item_kind
  output logic             m_axis_tlast_o,
  // configuration
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  localparam int unsigned STORE_DEPTH = (LINE_DEPTH < MAX_STORE) ? LINE_DEPTH : MAX_STORE;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam logic        REG_MAX_LINE = 1'b0;
  localparam logic        REG_HIDDEN   = 1'b1;

  // config registers
  logic [CFG_LINE_W-1:0] max_line_q;
  logic                  hidden_q;
  logic                  cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q <= CFG_LINE_W'(16);
      hidden_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr_i[2])
        REG_MAX_LINE: max_line_q <= pwdata_i[CFG_LINE_W-1:0];
        default:      hidden_q   <= pwdata_i[0];
      endcase
    end
  end

  always_comb begin
    case (paddr_i[2])
      REG_HIDDEN: prdata_o = {31'd0, hidden_q};
      default:    prdata_o = {{(32-CFG_LINE_W){1'b0}}, max_line_q};
    endcase
  end

  // line store: written by the front, read by the back
  logic [7:0]       line_store_q [STORE_DEPTH];
  store_wr_t        wr;
  logic [LEN_W-1:0] rd_addr;
  logic [7:0]       rd_data;

  always_ff @(posedge clk_i) begin
    if (wr.en) begin
      line_store_q[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end
  assign rd_data = line_store_q[rd_addr[ADDR_W-1:0]];

  // front -> queue -> back
  logic q_push, q_ready, q_pop, q_valid, line_done;
  cmd_t push_cmd, pop_cmd;

  tle_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (s_axis_tvalid_i),
    .rx_ready_o (s_axis_tready_o),
    .rx_byte_i  (s_axis_tdata_i),
    .max_line_i (max_line_q),
    .hidden_i   (hidden_q),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd),
    .wr_o       (wr),
    .line_done_i(line_done)
  );

  tle_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (pop_cmd)
  );

  logic [7:0]       out_byte;
  logic [LEN_W-1:0] out_len;

  tle_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (pop_cmd),
    .q_pop_o    (q_pop),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .line_done_o(line_done),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_kind_o (m_axis_tuser_o),
    .out_byte_o (out_byte),
    .out_len_o  (out_len),
    .out_last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_len, out_byte};

endmodule
`default_nettype wire

// ===== rtl/tle_checker.sv =====
`default_nettype none
module tle_checker import tle_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // a stalled beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // the end marker closes its run and carries no byte
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_END |->
      m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'd0)
    else $error("bad line end marker");

  // line bytes are never the final beat of an input byte
  a_line_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_LINE |-> !m_axis_tlast_o)
    else $error("line byte marked last");

  // length is zero except on the end marker
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != KIND_END |-> m_axis_tdata_o[15:8] == 8'd0)
    else $error("length set on non-end beat");

  // an end marker never comes right after an accepted beat marked last
  a_line_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i |=>
      !(m_axis_tvalid_o && m_axis_tuser_o == KIND_END && $past(m_axis_tlast_o)))
    else $error("end marker without line start");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);
`default_nettype wire
